@@ hw/rtl/rbsa_pkg.sv @@
// Package: constants, status codes and helpers for the ring-buffer scratch allocator.
package rbsa_pkg;
  localparam int BUFFER_BYTES = 65536;
  localparam int MIN_ALIGN = 4;
  localparam int WORDS = BUFFER_BYTES / 4;
  localparam int AW = $clog2(WORDS);
  localparam int OW = $clog2(BUFFER_BYTES) + 1;
  localparam int MINA_LOG = $clog2(MIN_ALIGN);

  localparam logic [31:0] PAD_WORD = 32'hFFFF_FFFF;
  localparam logic [31:0] FREE_BIT = 32'h8000_0000;

  localparam logic [2:0] ST_ALLOC = 3'd0;
  localparam logic [2:0] ST_FREED = 3'd1;
  localparam logic [2:0] ST_BACKUP = 3'd2;
  localparam logic [2:0] ST_FAIL = 3'd3;
  localparam logic [2:0] ST_FREE_BACKUP = 3'd4;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_BACKUP = 1'b1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  // Clamp a written capacity to a word multiple within 16 .. BUFFER_BYTES
  function automatic logic [OW-1:0] clamp_cap(input logic [16:0] v);
    logic [OW+16:0] c;
    c = {{OW{1'b0}}, v[16:2], 2'b00};
    if (c > (OW+17)'(BUFFER_BYTES)) c = (OW+17)'(BUFFER_BYTES);
    if (c < (OW+17)'(16)) c = (OW+17)'(16);
    return c[OW-1:0];
  endfunction
endpackage

@@ hw/rtl/ring_buffer_scratch_allocator_top.sv @@
// Ring-buffer scratch allocator: sequencer over a single-port word store.
// Allocate: fit check, a wrap marker when wrapping, header, padding; refused at acceptance
// or at the fit check. Free: scan back over padding to the header and mark it free, then
// move the tail past free blocks; refused at acceptance or on a freed header or word zero.
// One item at a time; the next is taken once the result is handed over.
// Reset: synchronous; head, tail and used clear, capacity 65536, no backup, store kept.
module ring_buffer_scratch_allocator_top import rbsa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [31:0] req_size,
  input  logic [16:0] req_align,
  input  logic [31:0] free_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [15:0] data_addr,
  output logic [16:0] used_bytes
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ACHK   = 4'd1;
  localparam logic [3:0] S_AHDR   = 4'd2;
  localparam logic [3:0] S_APAD   = 4'd3;
  localparam logic [3:0] S_FRD    = 4'd4;
  localparam logic [3:0] S_FCHK   = 4'd5;
  localparam logic [3:0] S_TRD    = 4'd6;
  localparam logic [3:0] S_TCHK   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;
  localparam logic [3:0] S_AWRAP  = 4'd9;

  logic [3:0]    state;
  logic [OW-1:0] capacity;
  logic          has_backup;
  logic [OW-1:0] head, tail, used;

  // Latched item
  logic [32:0]   size_r;    // rounded size
  logic [OW-1:0] align_r;
  logic [2:0]    st_r;
  logic [15:0]   addr_r;

  // Allocation working values
  logic [OW-1:0] blk_h;
  logic [OW-1:0] blk_data;
  logic [OW-1:0] blk_p;
  logic [OW-1:0] pad_q;
  logic [AW-1:0] scan_idx;

  // Word store
  logic [31:0]   mem [WORDS];
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata;
  logic [31:0]   mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_rdata <= mem[mem_addr];
  end

  // Alignment cleanup and size round-up
  logic [OW-1:0] align_in;
  logic [32:0]   size_up;
  always_comb begin
    if (req_align < 17'(MIN_ALIGN) || (req_align & (req_align - 17'd1)) != 17'd0)
      align_in = OW'(MIN_ALIGN);
    else
      align_in = OW'(req_align);
    size_up = ({1'b0, req_size} + 33'(MIN_ALIGN - 1)) & ~33'(MIN_ALIGN - 1);
  end

  // Fit computations for head placement and wrap placement
  logic [OW:0]   d1, d2;
  logic [33:0]   p1, p2;
  logic          live;
  always_comb begin
    d1 = ({1'b0, head} + (OW+1)'(4) + {1'b0, align_r} - (OW+1)'(1))
         & ~({1'b0, align_r} - (OW+1)'(1));
    d2 = ((OW+1)'(4) + {1'b0, align_r} - (OW+1)'(1)) & ~({1'b0, align_r} - (OW+1)'(1));
    p1 = 34'(d1) + {1'b0, size_r};
    p2 = 34'(d2) + {1'b0, size_r};
    live = (head != tail);
  end

  logic [30:0] hdr_size;
  logic [OW-1:0] nt;
  always_comb begin
    hdr_size = 31'(blk_p - blk_h);
    nt = tail + OW'(mem_rdata[30:0]);
  end

  assign in_stall = (state != S_IDLE) || out_valid;

  // Memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_addr = scan_idx;
    mem_wdata = PAD_WORD;
    unique case (state)
      S_AWRAP: begin
        mem_we = 1'b1;
        mem_addr = head[AW+1:2];
        mem_wdata = FREE_BIT | 32'(capacity - head);
      end
      S_AHDR: begin
        mem_we = 1'b1;
        mem_addr = blk_h[AW+1:2];
        mem_wdata = {1'b0, hdr_size};
      end
      S_APAD: begin
        mem_we = (pad_q < blk_data);
        mem_addr = pad_q[AW+1:2];
      end
      S_FCHK: begin
        mem_we = (mem_rdata != PAD_WORD) && !mem_rdata[31];
        mem_addr = scan_idx;
        mem_wdata = mem_rdata | FREE_BIT;
      end
      S_TRD: mem_addr = tail[AW+1:2];
      default: mem_addr = scan_idx;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      capacity <= clamp_cap(17'h1_0000);
      has_backup <= 1'b0;
      head <= '0;
      tail <= '0;
      used <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CAPACITY: begin
            capacity <= clamp_cap(cfg_data);
            head <= '0;
            tail <= '0;
            used <= '0;
          end
          REG_BACKUP: has_backup <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            size_r <= size_up;
            align_r <= align_in;
            addr_r <= '0;
            if (op == OP_ALLOC) begin
              if (33'(req_size) >= 33'(capacity)) begin
                st_r <= has_backup ? ST_BACKUP : ST_FAIL;
                state <= S_DONE;
              end else begin
                state <= S_ACHK;
              end
            end else begin
              if (free_addr >= 32'(capacity)) begin
                st_r <= has_backup ? ST_FREE_BACKUP : ST_FAIL;
                state <= S_DONE;
              end else if (free_addr[31:2] == 30'd0) begin
                st_r <= ST_FAIL;
                state <= S_DONE;
              end else begin
                scan_idx <= free_addr[AW+1:2] - AW'(1);
                state <= S_FRD;
              end
            end
          end
        end
        S_ACHK: begin
          st_r <= has_backup ? ST_BACKUP : ST_FAIL;
          state <= S_DONE;
          if (p1 < 34'(capacity)) begin
            if (!(live && head < tail && p1 >= 34'(tail))) begin
              blk_h <= head;
              blk_data <= d1[OW-1:0];
              blk_p <= p1[OW-1:0];
              state <= S_AHDR;
            end
          end else if (!(live && head < tail) && p2 < 34'(capacity)) begin
            if (!live) begin
              tail <= '0;
              blk_h <= '0;
              blk_data <= d2[OW-1:0];
              blk_p <= p2[OW-1:0];
              state <= S_AHDR;
            end else if (p2 < 34'(tail)) begin
              blk_h <= '0;
              blk_data <= d2[OW-1:0];
              blk_p <= p2[OW-1:0];
              state <= S_AWRAP;
            end
          end
        end
        S_AWRAP: state <= S_AHDR;
        S_AHDR: begin
          pad_q <= blk_h + OW'(4);
          state <= S_APAD;
        end
        S_APAD: begin
          if (pad_q < blk_data) begin
            pad_q <= pad_q + OW'(4);
          end else begin
            head <= blk_p;
            used <= used + (blk_p - blk_h);
            st_r <= ST_ALLOC;
            addr_r <= blk_data[15:0];
            state <= S_DONE;
          end
        end
        S_FRD: state <= S_FCHK;
        S_FCHK: begin
          if (mem_rdata == PAD_WORD) begin
            if (scan_idx == '0) begin
              st_r <= ST_FAIL;
              state <= S_DONE;
            end else begin
              scan_idx <= scan_idx - AW'(1);
              state <= S_FRD;
            end
          end else if (mem_rdata[31]) begin
            st_r <= ST_FAIL;
            state <= S_DONE;
          end else begin
            used <= (33'(mem_rdata[30:0]) >= 33'(used)) ? '0 : used - OW'(mem_rdata[30:0]);
            st_r <= ST_FREED;
            state <= S_TRD;
          end
        end
        S_TRD: state <= (tail == head) ? S_DONE : S_TCHK;
        S_TCHK: begin
          if (!mem_rdata[31] || mem_rdata[30:0] == 31'd0) begin
            state <= S_DONE;
          end else begin
            if (33'(tail) + 33'(mem_rdata[30:0]) >= 33'(capacity)) tail <= '0;
            else tail <= nt;
            state <= S_TRD;
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign status = st_r;
  assign data_addr = addr_r;
  assign used_bytes = used;

`ifndef SYNTH
  // A result appears only on leaving the final step
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE) else $error("result without completion");
  // No item is taken while a result waits
  a_no_take_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  // Used count never exceeds capacity
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= capacity) else $error("used count over capacity");
`endif
endmodule
